FILE: rtl/pmq_pkg.sv
// ----------------------------------------------------------------------------
// pmq_pkg: shared types and constants of the priority multi-queue scheduler
// Request and result words, slot record, controller commands and status.
// ----------------------------------------------------------------------------
package pmq_pkg;

    localparam int TASK_SLOTS_DEF   = 64;
    localparam int QUEUE_COUNT_DEF  = 16;
    localparam int TARGET_COUNT_DEF = 32;

    localparam logic [1:0] REQ_SUBMIT  = 2'd0;
    localparam logic [1:0] REQ_TICK    = 2'd1;
    localparam logic [1:0] REQ_SET_PRI = 2'd2;

    localparam logic [6:0] KEEP_RESET   = 7'd48;
    localparam logic [7:0] PRI_Q0_RESET = 8'd10;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [3:0]  queue_id;
        logic [31:0] seq_number;
        logic [4:0]  target_index;
        logic        wait_on_run;
        logic        wait_on_conf;
        logic [7:0]  priority_req;
        logic [31:0] run_busy_map;
        logic [31:0] conf_pending_map;
        logic [47:0] now_time;
    } pmq_req_t;

    typedef struct packed {
        logic       launched;
        logic [5:0] launch_slot;
        logic [3:0] launch_queue;
        logic [4:0] launch_target;
        logic       submit_ok;
        logic [5:0] submit_slot;
        logic [6:0] completed_count;
        logic [6:0] purged_count;
    } pmq_res_t;

    typedef struct packed {
        logic [3:0]  queue;
        logic [31:0] seq;
        logic [4:0]  target;
        logic        wait_run;
        logic        wait_conf;
    } slot_rec_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_SUB_SCAN,
        OP_SET_PRI,
        OP_PASS_INIT,
        OP_PASS,
        OP_CHECK,
        OP_PURGE_INIT,
        OP_PURGE_SCAN,
        OP_PURGE_FREE,
        OP_LAUNCH_INIT,
        OP_LAUNCH_SCAN,
        OP_LAUNCH_DO
    } dp_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SUB_SCAN,
        ST_PASS_INIT,
        ST_PASS,
        ST_CHECK,
        ST_CHECK_END,
        ST_PURGE_TEST,
        ST_PURGE_INIT,
        ST_PURGE_SCAN,
        ST_PURGE_FREE,
        ST_LAUNCH_INIT,
        ST_LAUNCH_SCAN,
        ST_LAUNCH_DO,
        ST_DONE
    } ctl_state_t;

    typedef struct packed {
        dp_op_t op;
    } pmq_cmd_t;

    typedef struct packed {
        logic [1:0] req_kind;
        logic       qid_ok;
        logic       slot_free;
        logic       slot_last;
        logic       scan_end;
        logic       queue_last;
        logic       rescan_any;
        logic       purge_need;
    } pmq_sts_t;

endpackage

FILE: rtl/pmq_ctrl.sv
// ----------------------------------------------------------------------------
// pmq_ctrl: scheduler sequencer
// Steps the datapath through submit, priority write and the tick phases.
// ----------------------------------------------------------------------------
module pmq_ctrl
    import pmq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    output logic     done,
    output pmq_cmd_t cmd,
    input  pmq_sts_t sts
);

    ctl_state_t state_reg;
    ctl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        done       = 1'b0;
        busy       = (state_reg != ST_IDLE);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.op     = OP_CAPTURE;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                unique case (sts.req_kind)
                    REQ_SUBMIT:  state_next = sts.qid_ok ? ST_SUB_SCAN : ST_DONE;
                    REQ_TICK:    state_next = ST_PASS_INIT;
                    REQ_SET_PRI:
                    begin
                        cmd.op     = OP_SET_PRI;
                        state_next = ST_DONE;
                    end
                    default:     state_next = ST_DONE;
                endcase
            end
            ST_SUB_SCAN:
            begin
                cmd.op = OP_SUB_SCAN;
                if (sts.slot_free || sts.slot_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_PASS_INIT:
            begin
                cmd.op     = OP_PASS_INIT;
                state_next = ST_PASS;
            end
            ST_PASS:
            begin
                cmd.op = OP_PASS;
                if (sts.scan_end)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                cmd.op = OP_CHECK;
                if (sts.queue_last)
                begin
                    state_next = ST_CHECK_END;
                end
            end
            ST_CHECK_END:
            begin
                // rescan any queue whose head just completed
                state_next = sts.rescan_any ? ST_PASS_INIT : ST_PURGE_TEST;
            end
            ST_PURGE_TEST:
            begin
                state_next = sts.purge_need ? ST_PURGE_INIT : ST_LAUNCH_INIT;
            end
            ST_PURGE_INIT:
            begin
                cmd.op     = OP_PURGE_INIT;
                state_next = ST_PURGE_SCAN;
            end
            ST_PURGE_SCAN:
            begin
                cmd.op = OP_PURGE_SCAN;
                if (sts.scan_end)
                begin
                    state_next = ST_PURGE_FREE;
                end
            end
            ST_PURGE_FREE:
            begin
                cmd.op     = OP_PURGE_FREE;
                state_next = ST_PURGE_TEST;
            end
            ST_LAUNCH_INIT:
            begin
                cmd.op     = OP_LAUNCH_INIT;
                state_next = ST_LAUNCH_SCAN;
            end
            ST_LAUNCH_SCAN:
            begin
                cmd.op = OP_LAUNCH_SCAN;
                if (sts.queue_last)
                begin
                    state_next = ST_LAUNCH_DO;
                end
            end
            ST_LAUNCH_DO:
            begin
                cmd.op     = OP_LAUNCH_DO;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                done       = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/pmq_datapath.sv
// ----------------------------------------------------------------------------
// pmq_datapath: task table, queue heads and selection logic
// Slot flags in flops, slot records and done stamps in memories, scanned
// one slot a cycle; queue heads and priorities in per-queue registers.
// ----------------------------------------------------------------------------
module pmq_datapath
    import pmq_pkg::*;
#(
    parameter int TASK_SLOTS   = TASK_SLOTS_DEF,
    parameter int QUEUE_COUNT  = QUEUE_COUNT_DEF,
    parameter int TARGET_COUNT = TARGET_COUNT_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  pmq_cmd_t   cmd,
    output pmq_sts_t   sts,
    input  pmq_req_t   req,
    input  logic [6:0] purge_keep,
    input  logic       done,
    output pmq_res_t   res
);

    localparam int SW = $clog2(TASK_SLOTS);
    localparam int QW = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;
    localparam int CW = $clog2(TASK_SLOTS + 1);
    localparam int KW = (CW > 7) ? CW : 7;
    localparam logic [SW-1:0] SLOT_LAST  = SW'(TASK_SLOTS - 1);
    localparam logic [QW-1:0] QUEUE_LAST = QW'(QUEUE_COUNT - 1);

    // memories
    slot_rec_t   rec_mem [TASK_SLOTS];
    logic [47:0] time_mem [TASK_SLOTS];
    slot_rec_t   rec_rd_reg;
    logic [47:0] time_rd_reg;

    // control state
    logic [TASK_SLOTS-1:0]  active_reg;
    logic [TASK_SLOTS-1:0]  running_reg;
    logic [TASK_SLOTS-1:0]  completed_reg;
    logic [QUEUE_COUNT-1:0] rescan_reg;
    logic [QUEUE_COUNT-1:0] ready_reg;
    logic [QUEUE_COUNT-1:0] hv_reg;
    logic [7:0]             pri_reg [QUEUE_COUNT];
    logic [SW-1:0]          sidx_reg;
    logic [QW-1:0]          qidx_reg;
    logic                   issue_reg;
    logic                   rd_v_reg;
    logic [SW-1:0]          sd_reg;
    logic [CW-1:0]          ccnt_reg;

    // payload
    pmq_req_t      req_reg;
    logic [SW-1:0] hslot_reg [QUEUE_COUNT];
    logic [31:0]   hseq_reg  [QUEUE_COUNT];
    logic [4:0]    htgt_reg  [QUEUE_COUNT];
    logic          hwr_reg   [QUEUE_COUNT];
    logic          hwc_reg   [QUEUE_COUNT];
    logic          pbv_reg;
    logic [47:0]   page_reg;
    logic [SW-1:0] pslot_reg;
    logic          lbv_reg;
    logic [7:0]    lbp_reg;
    logic [QW-1:0] lbq_reg;
    logic [CW-1:0] ccount_reg;
    logic [CW-1:0] pcount_reg;
    logic          launched_reg;
    logic [SW-1:0] lslot_reg;
    logic [QW-1:0] lqueue_reg;
    logic [4:0]    ltgt_reg;
    logic          sok_reg;
    logic [SW-1:0] sslot_reg;

    // combinational
    logic [QW-1:0] rq_idx;
    logic [QW-1:0] hq;
    logic [SW-1:0] hslot;
    logic          slot_free;
    logic          pass_take;
    logic          head_blocked;
    logic [47:0]   age;
    logic          purge_take;
    logic          launch_take;
    logic          launch_go;

    assign rq_idx = QW'(rec_rd_reg.queue);

    always_comb
    begin
        unique case (cmd.op)
            OP_PASS:      hq = rq_idx;
            OP_LAUNCH_DO: hq = lbq_reg;
            default:      hq = qidx_reg;
        endcase
    end

    assign hslot     = hslot_reg[hq];
    assign slot_free = !active_reg[sidx_reg] && !completed_reg[sidx_reg];

    assign pass_take = rd_v_reg && active_reg[sd_reg]
                       && (int'(rec_rd_reg.queue) < QUEUE_COUNT) && rescan_reg[hq]
                       && (!hv_reg[hq] || (rec_rd_reg.seq < hseq_reg[hq]));

    assign head_blocked =
        (hwr_reg[hq] && (int'(htgt_reg[hq]) < TARGET_COUNT)
                     && req_reg.run_busy_map[htgt_reg[hq]])
     || (hwc_reg[hq] && (int'(htgt_reg[hq]) < TARGET_COUNT)
                     && req_reg.conf_pending_map[htgt_reg[hq]]);

    assign age        = req_reg.now_time - time_rd_reg;
    assign purge_take = rd_v_reg && completed_reg[sd_reg] && (!pbv_reg || (age > page_reg));
    assign launch_take = ready_reg[hq] && (!lbv_reg || (pri_reg[hq] > lbp_reg));
    assign launch_go   = lbv_reg && (lbp_reg != 8'd0);

    // memories
    always_ff @(posedge clk)
    begin
        if ((cmd.op == OP_SUB_SCAN) && slot_free)
        begin
            rec_mem[sidx_reg] <= '{queue:     req_reg.queue_id,
                                   seq:       req_reg.seq_number,
                                   target:    req_reg.target_index,
                                   wait_run:  req_reg.wait_on_run,
                                   wait_conf: req_reg.wait_on_conf};
        end
        rec_rd_reg <= rec_mem[sidx_reg];
    end

    always_ff @(posedge clk)
    begin
        if ((cmd.op == OP_CHECK) && rescan_reg[hq] && hv_reg[hq]
            && running_reg[hslot] && !head_blocked)
        begin
            time_mem[hslot] <= req_reg.now_time;
        end
        time_rd_reg <= time_mem[sidx_reg];
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= '0;
            running_reg   <= '0;
            completed_reg <= '0;
            rescan_reg    <= '0;
            ready_reg     <= '0;
            hv_reg        <= '0;
            for (int q = 0; q < QUEUE_COUNT; q++)
            begin
                pri_reg[q] <= (q == 0) ? PRI_Q0_RESET : 8'd0;
            end
            sidx_reg  <= '0;
            qidx_reg  <= '0;
            issue_reg <= 1'b0;
            rd_v_reg  <= 1'b0;
            sd_reg    <= '0;
            ccnt_reg  <= '0;
        end
        else
        begin
            unique case (cmd.op)
                OP_CAPTURE:
                begin
                    sidx_reg   <= '0;
                    rescan_reg <= '1;
                    ready_reg  <= '0;
                end
                OP_SUB_SCAN:
                begin
                    if (slot_free)
                    begin
                        active_reg[sidx_reg]  <= 1'b1;
                        running_reg[sidx_reg] <= 1'b0;
                    end
                    else if (sidx_reg != SLOT_LAST)
                    begin
                        sidx_reg <= sidx_reg + 1'b1;
                    end
                end
                OP_SET_PRI:
                begin
                    if (int'(req_reg.queue_id) < QUEUE_COUNT)
                    begin
                        pri_reg[QW'(req_reg.queue_id)] <= req_reg.priority_req;
                    end
                end
                OP_PASS_INIT, OP_PURGE_INIT:
                begin
                    if (cmd.op == OP_PASS_INIT)
                    begin
                        hv_reg <= hv_reg & ~rescan_reg;
                    end
                    sidx_reg  <= '0;
                    qidx_reg  <= '0;
                    issue_reg <= 1'b1;
                    rd_v_reg  <= 1'b0;
                end
                OP_PASS, OP_PURGE_SCAN:
                begin
                    rd_v_reg <= issue_reg;
                    sd_reg   <= sidx_reg;
                    if (issue_reg)
                    begin
                        if (sidx_reg == SLOT_LAST)
                        begin
                            issue_reg <= 1'b0;
                        end
                        else
                        begin
                            sidx_reg <= sidx_reg + 1'b1;
                        end
                    end
                    if ((cmd.op == OP_PASS) && pass_take)
                    begin
                        hv_reg[hq] <= 1'b1;
                    end
                end
                OP_CHECK:
                begin
                    qidx_reg <= qidx_reg + 1'b1;
                    if (rescan_reg[hq])
                    begin
                        if (!hv_reg[hq])
                        begin
                            rescan_reg[hq] <= 1'b0;
                        end
                        else if (!running_reg[hslot])
                        begin
                            ready_reg[hq]  <= 1'b1;
                            rescan_reg[hq] <= 1'b0;
                        end
                        else if (head_blocked)
                        begin
                            rescan_reg[hq] <= 1'b0;
                        end
                        else
                        begin
                            // complete the head, keep the queue for a rescan
                            running_reg[hslot]   <= 1'b0;
                            active_reg[hslot]    <= 1'b0;
                            completed_reg[hslot] <= 1'b1;
                            ccnt_reg             <= ccnt_reg + 1'b1;
                        end
                    end
                end
                OP_PURGE_FREE:
                begin
                    if (pbv_reg)
                    begin
                        completed_reg[pslot_reg] <= 1'b0;
                        active_reg[pslot_reg]    <= 1'b0;
                        running_reg[pslot_reg]   <= 1'b0;
                        ccnt_reg                 <= ccnt_reg - 1'b1;
                    end
                end
                OP_LAUNCH_INIT:
                begin
                    qidx_reg <= '0;
                end
                OP_LAUNCH_SCAN:
                begin
                    qidx_reg <= qidx_reg + 1'b1;
                end
                OP_LAUNCH_DO:
                begin
                    if (launch_go)
                    begin
                        running_reg[hslot] <= 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_CAPTURE:
            begin
                req_reg      <= req;
                ccount_reg   <= '0;
                pcount_reg   <= '0;
                launched_reg <= 1'b0;
                lslot_reg    <= '0;
                lqueue_reg   <= '0;
                ltgt_reg     <= '0;
                sok_reg      <= 1'b0;
                sslot_reg    <= '0;
            end
            OP_SUB_SCAN:
            begin
                if (slot_free)
                begin
                    sok_reg   <= 1'b1;
                    sslot_reg <= sidx_reg;
                end
            end
            OP_PASS:
            begin
                if (pass_take)
                begin
                    hslot_reg[hq] <= sd_reg;
                    hseq_reg[hq]  <= rec_rd_reg.seq;
                    htgt_reg[hq]  <= rec_rd_reg.target;
                    hwr_reg[hq]   <= rec_rd_reg.wait_run;
                    hwc_reg[hq]   <= rec_rd_reg.wait_conf;
                end
            end
            OP_CHECK:
            begin
                if (rescan_reg[hq] && hv_reg[hq] && running_reg[hslot] && !head_blocked)
                begin
                    ccount_reg <= ccount_reg + 1'b1;
                end
            end
            OP_PURGE_INIT:
            begin
                pbv_reg <= 1'b0;
            end
            OP_PURGE_SCAN:
            begin
                if (purge_take)
                begin
                    pbv_reg   <= 1'b1;
                    page_reg  <= age;
                    pslot_reg <= sd_reg;
                end
            end
            OP_PURGE_FREE:
            begin
                if (pbv_reg)
                begin
                    pcount_reg <= pcount_reg + 1'b1;
                end
            end
            OP_LAUNCH_INIT:
            begin
                lbv_reg <= 1'b0;
            end
            OP_LAUNCH_SCAN:
            begin
                if (launch_take)
                begin
                    lbv_reg <= 1'b1;
                    lbp_reg <= pri_reg[hq];
                    lbq_reg <= qidx_reg;
                end
            end
            OP_LAUNCH_DO:
            begin
                if (launch_go)
                begin
                    launched_reg <= 1'b1;
                    lslot_reg    <= hslot;
                    lqueue_reg   <= lbq_reg;
                    ltgt_reg     <= htgt_reg[hq];
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        sts.req_kind   = req_reg.req_type;
        sts.qid_ok     = int'(req_reg.queue_id) < QUEUE_COUNT;
        sts.slot_free  = slot_free;
        sts.slot_last  = (sidx_reg == SLOT_LAST);
        sts.scan_end   = rd_v_reg && (sd_reg == SLOT_LAST);
        sts.queue_last = (qidx_reg == QUEUE_LAST);
        sts.rescan_any = |rescan_reg;
        sts.purge_need = KW'(ccnt_reg) > KW'(purge_keep);
    end

    always_comb
    begin
        res.launched        = launched_reg;
        res.launch_slot     = 6'(lslot_reg);
        res.launch_queue    = 4'(lqueue_reg);
        res.launch_target   = ltgt_reg;
        res.submit_ok       = sok_reg;
        res.submit_slot     = 6'(sslot_reg);
        res.completed_count = 7'(ccount_reg);
        res.purged_count    = 7'(pcount_reg);
    end

    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        ccnt_reg == CW'($countones(completed_reg)))
        else $error("completed count out of step with slot flags");

    a_active_xor_done: assert property (@(posedge clk) disable iff (!rst_n)
        (active_reg & completed_reg) == '0)
        else $error("slot both active and completed");

    a_running_active: assert property (@(posedge clk) disable iff (!rst_n)
        (running_reg & ~active_reg) == '0)
        else $error("running slot not active");

    a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(res.launched && res.submit_ok))
        else $error("word carries both a launch and a submit");

endmodule

FILE: rtl/priority_multi_queue_task_scheduler.sv
// ----------------------------------------------------------------------------
// priority_multi_queue_task_scheduler: task table scheduler over FIFO queues
// Submits tasks, sets queue priorities, and on a tick completes, purges
// and launches tasks.
// ----------------------------------------------------------------------------
//  channel   handshake                    payload
//  request   start, taken when !busy      req   (pmq_req_t)
//  result    done, one-cycle strobe       res   (pmq_res_t)
//  config    APB write, pready tied high  pwdata -> purge_keep at 0x0
//
//  Submit: slot search, one slot a cycle, ending at the first free slot.
//  Tick: rounds of a slot scan over the record memory and a queue check, repeated
//  while a head completed; then one scan of the stamp memory per task freed, then
//  a queue scan to launch. Priority write and unknown request need no scan.
//  Reset clears slot flags and restores priorities; no clearing pass.
//  The receiver cannot stall: done is high for one cycle per word.
// ----------------------------------------------------------------------------
module priority_multi_queue_task_scheduler
    import pmq_pkg::*;
#(
    parameter int TASK_SLOTS   = TASK_SLOTS_DEF,
    parameter int QUEUE_COUNT  = QUEUE_COUNT_DEF,
    parameter int TARGET_COUNT = TARGET_COUNT_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  pmq_req_t    req,
    output logic        done,
    output pmq_res_t    res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    pmq_cmd_t   cmd;
    pmq_sts_t   sts;
    logic [6:0] keep_reg;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {25'd0, keep_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keep_reg <= KEEP_RESET;
        end
        else if (psel && penable && pwrite && (paddr[2] == 1'b0))
        begin
            keep_reg <= pwdata[6:0];
        end
    end

    pmq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd),
        .sts   (sts)
    );

    pmq_datapath #(
        .TASK_SLOTS   (TASK_SLOTS),
        .QUEUE_COUNT  (QUEUE_COUNT),
        .TARGET_COUNT (TARGET_COUNT)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .req        (req),
        .purge_keep (keep_reg),
        .done       (done),
        .res        (res)
    );

endmodule
